>>> src/kvtok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvtok_pkg: shared types and constants of the key/value tokenizer
// Holds the word formats, the token kinds, the parse phases and the
// register map.
// ----------------------------------------------------------------------------
package kvtok_pkg;

  // Default depth of the result queue; must be at least two.
  localparam int unsigned ResultDepth = 4;

  // Fixed text bytes
  localparam logic [7:0] CharSpace     = 8'd32;
  localparam logic [7:0] CharTab       = 8'd9;
  localparam logic [7:0] CharNewline   = 8'd10;
  localparam logic [7:0] CharBackslash = 8'd92;

  // Register reset values
  localparam logic [7:0] QuoteReset      = 8'd34;
  localparam logic [7:0] SeparatorReset  = 8'd58;
  localparam logic [7:0] TerminatorReset = 8'd59;

  // Register index codes (byte address bits [3:2])
  localparam logic [1:0] RegQuote      = 2'd0;
  localparam logic [1:0] RegSeparator  = 2'd1;
  localparam logic [1:0] RegTerminator = 2'd2;

  // Token kinds
  localparam logic [1:0] KindName  = 2'd0;
  localparam logic [1:0] KindValue = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;
  localparam logic [1:0] KindDrop  = 2'd3;

  typedef enum logic [10:0] {
    PH_START    = 11'b000_0000_0001,
    PH_LEAD     = 11'b000_0000_0010,
    PH_BNAME    = 11'b000_0000_0100,
    PH_QNAME    = 11'b000_0000_1000,
    PH_QNAMEESC = 11'b000_0001_0000,
    PH_SKIPSEP  = 11'b000_0010_0000,
    PH_VLEAD    = 11'b000_0100_0000,
    PH_BVAL     = 11'b000_1000_0000,
    PH_QVAL     = 11'b001_0000_0000,
    PH_QVALESC  = 11'b010_0000_0000,
    PH_SKIPEND  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_word_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_byte;
  } token_word_t;

  // Parser outcome for one text word: up to two tokens, in order.
  typedef struct packed {
    logic [1:0]  count;
    token_word_t first;
    token_word_t second;
    phase_e      next_phase;
  } parse_res_t;

endpackage

>>> src/kvtok_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvtok_parser: next-phase and token logic for one text byte
// Handles the byte first, then the end of text; yields up to two tokens.
// ----------------------------------------------------------------------------
module kvtok_parser (
  input  kvtok_pkg::phase_e     phase_i,
  input  kvtok_pkg::text_word_t word_i,
  input  logic [7:0]            quote_i,
  input  logic [7:0]            separator_i,
  input  logic [7:0]            terminator_i,
  output kvtok_pkg::parse_res_t res_o
);

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == kvtok_pkg::CharSpace) || (b == kvtok_pkg::CharTab) ||
               (b == kvtok_pkg::CharNewline);
  endfunction

  logic              byte_nz;
  logic              at_end;
  logic              sep_is_term;
  kvtok_pkg::phase_e mid_phase;
  logic              byte_hit;
  logic [1:0]        byte_kind;
  logic [7:0]        byte_val;
  logic              end_hit;
  logic [1:0]        end_kind;
  kvtok_pkg::token_word_t byte_tok;
  kvtok_pkg::token_word_t end_tok;

  assign byte_nz     = (word_i.text_byte != 8'd0);
  assign at_end      = word_i.text_end | ~byte_nz;
  assign sep_is_term = (separator_i == terminator_i);

  // Byte step
  always_comb begin
    mid_phase = phase_i;
    byte_hit  = 1'b0;
    byte_kind = kvtok_pkg::KindName;
    byte_val  = word_i.text_byte;
    if (byte_nz) begin
      unique case (phase_i)
        kvtok_pkg::PH_START, kvtok_pkg::PH_LEAD: begin
          if (is_space(word_i.text_byte)) begin
            mid_phase = kvtok_pkg::PH_LEAD;
          end else if (word_i.text_byte == quote_i) begin
            mid_phase = kvtok_pkg::PH_QNAME;
          end else if (word_i.text_byte == separator_i) begin
            if (sep_is_term) begin
              byte_hit  = 1'b1;
              byte_kind = kvtok_pkg::KindDrop;
              mid_phase = kvtok_pkg::PH_START;
            end else begin
              mid_phase = kvtok_pkg::PH_VLEAD;
            end
          end else begin
            byte_hit  = 1'b1;
            mid_phase = kvtok_pkg::PH_BNAME;
          end
        end
        kvtok_pkg::PH_BNAME: begin
          if (word_i.text_byte == separator_i) begin
            if (sep_is_term) begin
              byte_hit  = 1'b1;
              byte_kind = kvtok_pkg::KindDrop;
              mid_phase = kvtok_pkg::PH_START;
            end else begin
              mid_phase = kvtok_pkg::PH_VLEAD;
            end
          end else if (is_space(word_i.text_byte)) begin
            mid_phase = kvtok_pkg::PH_SKIPSEP;
          end else begin
            byte_hit = 1'b1;
          end
        end
        kvtok_pkg::PH_QNAME: begin
          if (word_i.text_byte == quote_i) begin
            mid_phase = kvtok_pkg::PH_SKIPSEP;
          end else if (word_i.text_byte == kvtok_pkg::CharBackslash) begin
            mid_phase = kvtok_pkg::PH_QNAMEESC;
          end else begin
            byte_hit = 1'b1;
          end
        end
        kvtok_pkg::PH_QNAMEESC: begin
          byte_hit  = 1'b1;
          mid_phase = kvtok_pkg::PH_QNAME;
        end
        kvtok_pkg::PH_SKIPSEP: begin
          if (word_i.text_byte == separator_i) begin
            if (sep_is_term) begin
              byte_hit  = 1'b1;
              byte_kind = kvtok_pkg::KindDrop;
              mid_phase = kvtok_pkg::PH_START;
            end else begin
              mid_phase = kvtok_pkg::PH_VLEAD;
            end
          end else if (word_i.text_byte == terminator_i) begin
            byte_hit  = 1'b1;
            byte_kind = kvtok_pkg::KindDrop;
            mid_phase = kvtok_pkg::PH_START;
          end
        end
        kvtok_pkg::PH_VLEAD: begin
          if (is_space(word_i.text_byte)) begin
            mid_phase = kvtok_pkg::PH_VLEAD;
          end else if (word_i.text_byte == quote_i) begin
            mid_phase = kvtok_pkg::PH_QVAL;
          end else if (word_i.text_byte == terminator_i) begin
            byte_hit  = 1'b1;
            byte_kind = kvtok_pkg::KindDone;
            mid_phase = kvtok_pkg::PH_START;
          end else begin
            byte_hit  = 1'b1;
            byte_kind = kvtok_pkg::KindValue;
            mid_phase = kvtok_pkg::PH_BVAL;
          end
        end
        kvtok_pkg::PH_BVAL: begin
          byte_hit = 1'b1;
          if (word_i.text_byte == terminator_i) begin
            byte_kind = kvtok_pkg::KindDone;
            mid_phase = kvtok_pkg::PH_START;
          end else if (is_space(word_i.text_byte)) begin
            byte_kind = kvtok_pkg::KindDone;
            mid_phase = kvtok_pkg::PH_SKIPEND;
          end else begin
            byte_kind = kvtok_pkg::KindValue;
          end
        end
        kvtok_pkg::PH_QVAL: begin
          if (word_i.text_byte == quote_i) begin
            byte_hit  = 1'b1;
            byte_kind = kvtok_pkg::KindDone;
            mid_phase = kvtok_pkg::PH_SKIPEND;
          end else if (word_i.text_byte == kvtok_pkg::CharBackslash) begin
            mid_phase = kvtok_pkg::PH_QVALESC;
          end else begin
            byte_hit  = 1'b1;
            byte_kind = kvtok_pkg::KindValue;
          end
        end
        kvtok_pkg::PH_QVALESC: begin
          byte_hit  = 1'b1;
          byte_kind = kvtok_pkg::KindValue;
          mid_phase = kvtok_pkg::PH_QVAL;
        end
        kvtok_pkg::PH_SKIPEND: begin
          if (word_i.text_byte == terminator_i) begin
            mid_phase = kvtok_pkg::PH_START;
          end
        end
        default: begin
          mid_phase = kvtok_pkg::PH_START;
        end
      endcase
    end
    // marks carry a zero byte
    if (byte_kind == kvtok_pkg::KindDone || byte_kind == kvtok_pkg::KindDrop) begin
      byte_val = 8'd0;
    end
  end

  // End-of-text step
  always_comb begin
    end_hit  = 1'b0;
    end_kind = kvtok_pkg::KindDrop;
    if (at_end) begin
      unique case (mid_phase)
        kvtok_pkg::PH_LEAD, kvtok_pkg::PH_BNAME, kvtok_pkg::PH_QNAME,
        kvtok_pkg::PH_QNAMEESC, kvtok_pkg::PH_SKIPSEP: begin
          end_hit = 1'b1;
        end
        kvtok_pkg::PH_VLEAD, kvtok_pkg::PH_BVAL, kvtok_pkg::PH_QVAL,
        kvtok_pkg::PH_QVALESC: begin
          end_hit  = 1'b1;
          end_kind = kvtok_pkg::KindDone;
        end
        default: begin
          end_hit = 1'b0;
        end
      endcase
    end
  end

  assign byte_tok = '{token_kind: byte_kind, token_byte: byte_val};
  assign end_tok  = '{token_kind: end_kind, token_byte: 8'd0};

  assign res_o.count      = {1'b0, byte_hit} + {1'b0, end_hit};
  assign res_o.first      = byte_hit ? byte_tok : end_tok;
  assign res_o.second     = end_tok;
  assign res_o.next_phase = at_end ? kvtok_pkg::PH_START : mid_phase;

endmodule

>>> src/kvtok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvtok_fifo: result queue taking up to two tokens per cycle
// Pops one token per handshake; head entry drives the output word.
// ----------------------------------------------------------------------------
module kvtok_fifo #(
  parameter int unsigned Depth = kvtok_pkg::ResultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  kvtok_pkg::token_word_t push_first_i,
  input  kvtok_pkg::token_word_t push_second_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output kvtok_pkg::token_word_t word_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] RoomMax  = CountW'(Depth - 2);

  function automatic logic [AddrW-1:0] bump(input logic [AddrW-1:0] p);
    bump = (p == LastAddr) ? '0 : p + AddrW'(1);
  endfunction

  kvtok_pkg::token_word_t mem_q [Depth];
  logic [AddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  wr_next;
  logic              pop;

  assign pop     = valid_o & ~stall_i;
  assign wr_next = bump(wr_q);
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= RoomMax);
  assign word_o  = mem_q[rd_q];

  always_comb begin
    rd_d    = pop ? bump(rd_q) : rd_q;
    count_d = count_q + CountW'(push_cnt_i) - CountW'(pop);
    unique case (push_cnt_i)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = bump(wr_next);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push_first_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("result queue count beyond depth");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i == 2'd0) && !pop |=> $stable(count_q) && $stable(rd_q) && $stable(wr_q))
    else $error("result queue moved without push or pop");

  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i == 2'd2) && !pop |=> count_q == $past(count_q) + CountW'(2))
    else $error("double push not counted");

endmodule

>>> src/key_value_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_text_tokenizer_unit: splits text into name/value pairs
// Streams name bytes, value bytes and pair complete/dropped marks.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | word
//  ---------+-----+------------------------+-----------------------------
//  text     | in  | text_valid_i/_stall_o  | text_word_i  (byte, end)
//  token    | out | token_valid_o/_stall_i | token_word_o (kind, byte)
//  config   | in  | APB psel/penable       | quote, separator, terminator
//
//  One text word is accepted per cycle while the result queue has room for
//  two tokens; the parse phase is updated at that same edge.
//  A word's tokens (zero to two) are written to the queue at that edge;
//  the token port drains one word per cycle while token_stall_i is low.
//  The token port limits throughput: words that yield two tokens fill the
//  queue and stall the text port until it drains.
//  Reset puts the phase at start of text, empties the queue and loads the
//  default quote, separator and terminator bytes. No clearing pass.
//
module key_value_text_tokenizer_unit #(
  parameter int unsigned ResultDepth = kvtok_pkg::ResultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // text words
  input  logic                   text_valid_i,
  output logic                   text_stall_o,
  input  kvtok_pkg::text_word_t  text_word_i,
  // token words
  output logic                   token_valid_o,
  input  logic                   token_stall_i,
  output kvtok_pkg::token_word_t token_word_o,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  kvtok_pkg::phase_e     phase_q, phase_d;
  logic [7:0]            quote_q, separator_q, terminator_q;
  logic                  text_acc;
  logic                  room;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  kvtok_pkg::parse_res_t parse_res;
  logic [1:0]            push_cnt;

  // Register port: always ready; index from the word address.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      kvtok_pkg::RegQuote:      prdata = {24'd0, quote_q};
      kvtok_pkg::RegSeparator:  prdata = {24'd0, separator_q};
      kvtok_pkg::RegTerminator: prdata = {24'd0, terminator_q};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q      <= kvtok_pkg::QuoteReset;
      separator_q  <= kvtok_pkg::SeparatorReset;
      terminator_q <= kvtok_pkg::TerminatorReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kvtok_pkg::RegQuote:      quote_q      <= pwdata[7:0];
        kvtok_pkg::RegSeparator:  separator_q  <= pwdata[7:0];
        kvtok_pkg::RegTerminator: terminator_q <= pwdata[7:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  // Hold the text port while the queue cannot take a full pair of tokens.
  assign text_stall_o = ~room;
  assign text_acc     = text_valid_i & room;

  kvtok_parser u_parser (
    .phase_i      (phase_q),
    .word_i       (text_word_i),
    .quote_i      (quote_q),
    .separator_i  (separator_q),
    .terminator_i (terminator_q),
    .res_o        (parse_res)
  );

  // Advance the phase only on an accepted word.
  assign phase_d  = text_acc ? parse_res.next_phase : phase_q;
  assign push_cnt = text_acc ? parse_res.count : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kvtok_pkg::PH_START;
    end else begin
      phase_q <= phase_d;
    end
  end

  kvtok_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_cnt_i    (push_cnt),
    .push_first_i  (parse_res.first),
    .push_second_i (parse_res.second),
    .room_o        (room),
    .valid_o       (token_valid_o),
    .stall_i       (token_stall_i),
    .word_o        (token_word_o)
  );

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc && text_word_i.text_end |=> phase_q == kvtok_pkg::PH_START)
    else $error("phase not back at start after end of text");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_acc |=> $stable(phase_q))
    else $error("phase moved without an accepted word");

  a_quote_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (reg_idx == kvtok_pkg::RegQuote) |=> quote_q == $past(pwdata[7:0]))
    else $error("quote register write lost");

endmodule
